// ===== rtl/esu_pkg.sv =====
package esu_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned OCT_W       = 9;
  localparam int unsigned HACC_W      = 16;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LOW       = 8'h20;
  localparam logic [7:0] CH_HIGH      = 8'h7E;
  localparam logic [7:0] CH_E         = 8'h45;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [7:0] CODE_ESC = 8'h1B;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_DEL = 8'h7F;
  localparam logic [7:0] CTRL_MASK = 8'h1F;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [1:0]                  count;
  } burst_t;

endpackage

// ===== rtl/esu_if.sv =====
interface esu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface esu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== rtl/escape_sequence_unescaper.sv =====
// Escape-sequence unescaper: printable escaped text in, raw bytes out.
// in_ch carries one in_byte per transaction; out_ch carries out_byte with
// last_of_run set on the final byte that one input byte produced. Input
// bytes outside 0x20..0x7E and bytes that only advance an escape produce
// nothing. wr_en/wr_data write utf8_enable, which turns on the \u escape;
// write it only while no transaction is in flight.
// An accepted input byte is held in the input register; from there its
// output bytes load into the output burst register, which drives out_ch.
// Throughput: one input byte per cycle while each yields at most one output
// byte and the receiver is ready; an input byte yielding more than one byte
// (octal end, UTF-8) holds the output register until all are taken, and
// input holds off after one more byte is buffered.
// Reset clears the parser to plain text, utf8_enable to 0 and empties both
// the input register and the output burst.
// When the receiver stalls, the output burst holds and the input register
// fills, then in_ch.ready drops until the burst drains.
module escape_sequence_unescaper #(
  parameter int unsigned HEX_DIGITS = 4
) (
  input  logic      clk,
  input  logic      rst,
  esu_in_if.sink    in_ch,
  esu_out_if.source out_ch,
  input  logic      wr_en,
  input  logic      wr_data
);

  logic            utf8_enable;
  logic            burst_free;
  esu_pkg::burst_t load;

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_enable <= 1'b0;
    end else if (wr_en) begin
      utf8_enable <= wr_data;
    end
  end

  esu_decode #(
    .HEX_DIGITS(HEX_DIGITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .utf8_enable (utf8_enable),
    .burst_free  (burst_free),
    .load        (load)
  );

  esu_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .burst_free (burst_free),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/esu_decode.sv =====
module esu_decode #(
  parameter int unsigned HEX_DIGITS = 4
) (
  input  logic            clk,
  input  logic            rst,
  esu_in_if.sink          in_ch,
  input  logic            utf8_enable,
  input  logic            burst_free,
  output esu_pkg::burst_t load
);

  localparam int unsigned CW = $clog2(HEX_DIGITS + 1);

  typedef enum logic [2:0] {
    M_PLAIN = 3'd0,
    M_BSL   = 3'd1,
    M_CARET = 3'd2,
    M_OCT1  = 3'd3,
    M_OCT2  = 3'd4,
    M_OCT3  = 3'd5,
    M_UNI   = 3'd6
  } mode_t;

  mode_t                            mode;
  mode_t                            mode_next;
  logic [esu_pkg::OCT_W-1:0]        oacc;
  logic [esu_pkg::OCT_W-1:0]        oacc_next;
  logic [CW-1:0]                    hcnt;
  logic [CW-1:0]                    hcnt_next;
  logic [CW-1:0]                    hcnt_inc;
  logic [esu_pkg::HACC_W-1:0]       hacc;
  logic [esu_pkg::HACC_W-1:0]       hacc_next;
  logic [esu_pkg::HACC_W-1:0]       hacc_shift;
  logic [7:0]                       byte_q;
  logic                             full;
  logic                             fire;
  logic                             is_oct;
  logic                             is_dec;
  logic                             printable;
  logic [7:0]                       mapped;
  esu_pkg::burst_t                  res;

  assign fire        = full && burst_free;
  assign in_ch.ready = !full || burst_free;
  assign is_oct      = (byte_q >= esu_pkg::CH_ZERO) && (byte_q <= esu_pkg::CH_SEVEN);
  assign is_dec      = (byte_q >= esu_pkg::CH_ZERO) && (byte_q <= esu_pkg::CH_NINE);
  assign printable   = (byte_q >= esu_pkg::CH_LOW) && (byte_q <= esu_pkg::CH_HIGH);
  assign hacc_shift  = {hacc[esu_pkg::HACC_W-5:0], byte_q[3:0]};
  assign hcnt_inc    = hcnt + CW'(1);

  always_comb begin
    case (byte_q)
      esu_pkg::CH_E:        mapped = esu_pkg::CODE_ESC;
      esu_pkg::CH_B:        mapped = esu_pkg::CODE_BS;
      esu_pkg::CH_F:        mapped = esu_pkg::CODE_FF;
      esu_pkg::CH_N:        mapped = esu_pkg::CODE_LF;
      esu_pkg::CH_R:        mapped = esu_pkg::CODE_CR;
      esu_pkg::CH_T:        mapped = esu_pkg::CODE_TAB;
      esu_pkg::CH_QUESTION: mapped = esu_pkg::CODE_DEL;
      default:              mapped = byte_q;
    endcase
  end

  always_comb begin
    mode_next = mode;
    oacc_next = oacc;
    hcnt_next = hcnt;
    hacc_next = hacc;
    res       = '0;
    if (printable) begin
      case (mode)
        M_PLAIN: begin
          if (byte_q == esu_pkg::CH_BACKSLASH) begin
            mode_next = M_BSL;
          end else if (byte_q == esu_pkg::CH_CARET) begin
            mode_next = M_CARET;
          end else begin
            res.data[0] = byte_q;
            res.count   = 2'd1;
          end
        end
        M_BSL: begin
          mode_next = M_PLAIN;
          if (mapped == byte_q && byte_q == esu_pkg::CH_U && utf8_enable) begin
            mode_next = M_UNI;
            hcnt_next = '0;
            hacc_next = '0;
          end else if (mapped == byte_q && is_oct) begin
            mode_next = M_OCT1;
            oacc_next = {{(esu_pkg::OCT_W-3){1'b0}}, byte_q[2:0]};
          end else begin
            res.data[0] = mapped;
            res.count   = 2'd1;
          end
        end
        M_CARET: begin
          mode_next   = M_PLAIN;
          res.data[0] = (byte_q == esu_pkg::CH_QUESTION) ? esu_pkg::CODE_DEL
                                                          : (byte_q & esu_pkg::CTRL_MASK);
          res.count   = 2'd1;
        end
        M_OCT1, M_OCT2, M_OCT3: begin
          if (is_oct && mode != M_OCT3) begin
            oacc_next = {oacc[esu_pkg::OCT_W-4:0], byte_q[2:0]};
            mode_next = (mode == M_OCT1) ? M_OCT2 : M_OCT3;
          end else begin
            mode_next   = M_PLAIN;
            res.data[0] = oacc[7:0];
            res.count   = 2'd1;
            if (byte_q == esu_pkg::CH_BACKSLASH) begin
              mode_next = M_BSL;
            end else if (byte_q == esu_pkg::CH_CARET) begin
              mode_next = M_CARET;
            end else begin
              res.data[1] = byte_q;
              res.count   = 2'd2;
            end
          end
        end
        M_UNI: begin
          if (is_dec) begin
            hacc_next = hacc_shift;
            hcnt_next = hcnt_inc;
            if (hcnt_inc >= CW'(HEX_DIGITS)) begin
              mode_next = M_PLAIN;
              hcnt_next = '0;
              if (hacc_shift[15:7] == '0) begin
                res.data[0] = hacc_shift[7:0];
                res.count   = 2'd1;
              end else if (hacc_shift[15:11] == '0) begin
                res.data[0] = esu_pkg::UTF8_LEAD2 | {3'b000, hacc_shift[10:6]};
                res.data[1] = esu_pkg::UTF8_CONT | {2'b00, hacc_shift[5:0]};
                res.count   = 2'd2;
              end else begin
                res.data[0] = esu_pkg::UTF8_LEAD3 | {4'b0000, hacc_shift[15:12]};
                res.data[1] = esu_pkg::UTF8_CONT | {2'b00, hacc_shift[11:6]};
                res.data[2] = esu_pkg::UTF8_CONT | {2'b00, hacc_shift[5:0]};
                res.count   = 2'd3;
              end
            end
          end
        end
        default: begin
          mode_next = M_PLAIN;
        end
      endcase
    end
  end

  assign load = fire ? res : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_PLAIN;
      oacc <= '0;
      hcnt <= '0;
      hacc <= '0;
      full <= 1'b0;
    end else begin
      if (fire) begin
        mode <= mode_next;
        oacc <= oacc_next;
        hcnt <= hcnt_next;
        hacc <= hacc_next;
      end
      if (in_ch.valid && in_ch.ready) begin
        full <= 1'b1;
      end else if (fire) begin
        full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_q <= in_ch.in_byte;
    end
  end

  a_hcnt_bound: assert property (@(posedge clk) disable iff (rst)
    (mode == M_UNI) |-> (hcnt < CW'(HEX_DIGITS)))
    else $error("digit count reached limit inside escape");

  a_idle_no_load: assert property (@(posedge clk) disable iff (rst)
    !full |-> (load.count == 2'd0))
    else $error("load without buffered transaction");

endmodule

// ===== rtl/esu_burst.sv =====
module esu_burst (
  input  logic            clk,
  input  logic            rst,
  input  esu_pkg::burst_t load,
  output logic            burst_free,
  esu_out_if.source       out_ch
);

  logic [esu_pkg::MAX_RESULTS-1:0][7:0] data;
  logic [1:0]                           cnt;
  logic [1:0]                           idx;
  logic                                 take;
  logic                                 is_last;

  assign is_last            = (idx == cnt - 2'd1);
  assign take               = out_ch.valid && out_ch.ready;
  assign burst_free         = (cnt == 2'd0) || (take && is_last);
  assign out_ch.valid       = (cnt != 2'd0);
  assign out_ch.out_byte    = data[idx];
  assign out_ch.last_of_run = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (burst_free) begin
      cnt <= load.count;
      idx <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_free) begin
      data <= load.data;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd0) |-> (idx < cnt))
    else $error("burst index past count");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (load.count != 2'd0) |-> burst_free)
    else $error("burst loaded while still draining");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (cnt == 2'd0))
    else $error("burst not empty after reset");

endmodule

// ===== tb/escape_sequence_unescaper_tb.sv =====
`timescale 1ns / 100ps

module escape_sequence_unescaper_tb;

  localparam int unsigned HEX_DIGITS = 4;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 112;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_BSLASH,
    MODE_CARET,
    MODE_OCT1,
    MODE_OCT2,
    MODE_OCT3,
    MODE_UNI
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic wr_data = 1'b0;

  esu_in_if in_ch ();
  esu_out_if out_ch ();

  escape_sequence_unescaper #(
    .HEX_DIGITS(HEX_DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .wr_en(wr_en),
    .wr_data(wr_data)
  );

  always #4 clk = ~clk;

  // decoder state mirror
  parse_mode_t mode = MODE_PLAIN;
  logic [8:0] oct_acc = '0;
  logic [15:0] hex_acc = '0;
  logic [2:0] hex_count = '0;
  logic utf8_on = 1'b0;

  logic [7:0] text_q[$];
  decoded_t decoded_q[$];
  decoded_t want;

  int errors = 0;
  int items_in = 0;
  int bytes_out = 0;
  int multi_runs = 0;
  int phases = 0;
  int stall_cycles = 0;
  int src_gap = 0;
  int src_calm = 0;
  int sink_hold = 0;
  int sink_calm = 0;

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // plain-text handling of one byte; returns 1 when the byte goes out as itself
  function automatic logic plain_emits(input logic [7:0] c);
    if (c == esu_pkg::CH_BACKSLASH) begin
      mode = MODE_BSLASH;
      return 1'b0;
    end
    if (c == esu_pkg::CH_CARET) begin
      mode = MODE_CARET;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void unescape_byte(input logic [7:0] c);
    logic [7:0] burst[$];
    logic [7:0] r;
    logic is_oct;
    logic is_dec;
    decoded_t d;
    is_oct = (c >= esu_pkg::CH_ZERO) && (c <= esu_pkg::CH_SEVEN);
    is_dec = (c >= esu_pkg::CH_ZERO) && (c <= esu_pkg::CH_NINE);
    if (c < esu_pkg::CH_LOW || c > esu_pkg::CH_HIGH) return;
    case (mode)
      MODE_PLAIN: begin
        if (plain_emits(c)) burst.push_back(c);
      end
      MODE_BSLASH: begin
        mode = MODE_PLAIN;
        r = c;
        case (c)
          esu_pkg::CH_E: r = esu_pkg::CODE_ESC;
          esu_pkg::CH_B: r = esu_pkg::CODE_BS;
          esu_pkg::CH_F: r = esu_pkg::CODE_FF;
          esu_pkg::CH_N: r = esu_pkg::CODE_LF;
          esu_pkg::CH_R: r = esu_pkg::CODE_CR;
          esu_pkg::CH_T: r = esu_pkg::CODE_TAB;
          esu_pkg::CH_CARET: r = esu_pkg::CH_CARET;
          esu_pkg::CH_QUESTION: r = esu_pkg::CODE_DEL;
          default: begin
            if (c == esu_pkg::CH_U && utf8_on) begin
              mode = MODE_UNI;
              hex_count = '0;
              hex_acc = '0;
            end else if (is_oct) begin
              mode = MODE_OCT1;
              oct_acc = {6'd0, c[2:0]};
            end
          end
        endcase
        if (mode == MODE_PLAIN) burst.push_back(r);
      end
      MODE_CARET: begin
        burst.push_back((c == esu_pkg::CH_QUESTION) ? esu_pkg::CODE_DEL
                                                    : (c & esu_pkg::CTRL_MASK));
        mode = MODE_PLAIN;
      end
      MODE_OCT1, MODE_OCT2, MODE_OCT3: begin
        if (mode != MODE_OCT3 && is_oct) begin
          oct_acc = {oct_acc[5:0], c[2:0]};
          mode = (mode == MODE_OCT1) ? MODE_OCT2 : MODE_OCT3;
        end else begin
          mode = MODE_PLAIN;
          burst.push_back(oct_acc[7:0]);
          if (plain_emits(c)) burst.push_back(c);
        end
      end
      MODE_UNI: begin
        if (is_dec) begin
          hex_acc = {hex_acc[11:0], c[3:0]};
          hex_count = hex_count + 3'd1;
          if (hex_count >= HEX_DIGITS) begin
            if (hex_acc < 16'h0080) begin
              burst.push_back(hex_acc[7:0]);
            end else if (hex_acc < 16'h0800) begin
              burst.push_back(esu_pkg::UTF8_LEAD2 | {3'd0, hex_acc[10:6]});
              burst.push_back(esu_pkg::UTF8_CONT | {2'd0, hex_acc[5:0]});
            end else begin
              burst.push_back(esu_pkg::UTF8_LEAD3 | {4'd0, hex_acc[15:12]});
              burst.push_back(esu_pkg::UTF8_CONT | {2'd0, hex_acc[11:6]});
              burst.push_back(esu_pkg::UTF8_CONT | {2'd0, hex_acc[5:0]});
            end
            mode = MODE_PLAIN;
            hex_count = '0;
          end
        end
      end
      default: mode = MODE_PLAIN;
    endcase
    if (burst.size() > 1) multi_runs++;
    foreach (burst[i]) begin
      d.out_byte = burst[i];
      d.last_of_run = (i == burst.size() - 1);
      decoded_q.push_back(d);
    end
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endfunction

  function automatic logic [7:0] pick_printable();
    return 8'($urandom_range(esu_pkg::CH_LOW, esu_pkg::CH_HIGH));
  endfunction

  function automatic void queue_random_sequence();
    int kind;
    int n;
    int zeros;
    int junk_at;
    logic [7:0] ch;
    kind = int'($urandom_range(0, 99));
    if (kind < 30) begin
      text_q.push_back(pick_printable());
    end else if (kind < 50) begin
      text_q.push_back(esu_pkg::CH_BACKSLASH);
      case ($urandom_range(0, 10))
        0: ch = esu_pkg::CH_E;
        1: ch = esu_pkg::CH_B;
        2: ch = esu_pkg::CH_F;
        3: ch = esu_pkg::CH_N;
        4: ch = esu_pkg::CH_R;
        5: ch = esu_pkg::CH_T;
        6: ch = esu_pkg::CH_CARET;
        7: ch = esu_pkg::CH_QUESTION;
        8: ch = esu_pkg::CH_U;
        9: ch = esu_pkg::CH_BACKSLASH;
        default: ch = pick_printable();
      endcase
      text_q.push_back(ch);
    end else if (kind < 60) begin
      text_q.push_back(esu_pkg::CH_CARET);
      text_q.push_back(pick_printable());
    end else if (kind < 75) begin
      text_q.push_back(esu_pkg::CH_BACKSLASH);
      n = int'($urandom_range(1, 3));
      for (int i = 0; i < n; i++) begin
        text_q.push_back(8'($urandom_range(esu_pkg::CH_ZERO, esu_pkg::CH_SEVEN)));
      end
    end else if (kind < 90) begin
      text_q.push_back(esu_pkg::CH_BACKSLASH);
      text_q.push_back(esu_pkg::CH_U);
      zeros = int'($urandom_range(0, 3));
      junk_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : -1;
      for (int i = 0; i < HEX_DIGITS; i++) begin
        if (i == junk_at) begin
          ch = pick_printable();
          if (ch >= esu_pkg::CH_ZERO && ch <= esu_pkg::CH_NINE) ch = ch + 8'd10;
          text_q.push_back(ch);
        end
        if (i < zeros) begin
          text_q.push_back(esu_pkg::CH_ZERO);
        end else begin
          text_q.push_back(8'($urandom_range(esu_pkg::CH_ZERO, esu_pkg::CH_NINE)));
        end
      end
    end else begin
      n = int'($urandom_range(1, 3));
      for (int i = 0; i < n; i++) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (text_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_utf8_enable(input logic v);
    wr_en <= 1'b1;
    wr_data <= v;
    utf8_on = v;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // source side: drive queued text bytes, predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        unescape_byte(in_ch.in_byte);
        items_in++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold until taken
      end else if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= text_q.pop_front();
        if (src_calm > 0) begin
          src_calm--;
          src_gap = 0;
        end else begin
          src_gap = pick_gap();
          if ($urandom_range(0, 99) < 3) src_calm = int'($urandom_range(20, 80));
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // sink side: check each transaction against the oldest decoded byte
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          note_error($sformatf("unexpected byte 0x%02h last=%0b",
                               out_ch.out_byte, out_ch.last_of_run));
        end else begin
          want = decoded_q.pop_front();
          if (want.out_byte !== out_ch.out_byte || want.last_of_run !== out_ch.last_of_run) begin
            note_error($sformatf("byte %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                                 bytes_out, want.out_byte, want.last_of_run,
                                 out_ch.out_byte, out_ch.last_of_run));
          end
        end
        bytes_out++;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_calm > 0) begin
          sink_calm--;
        end else begin
          sink_hold = pick_gap();
          if ($urandom_range(0, 99) < 3) sink_calm = int'($urandom_range(20, 80));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("no transaction for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes, escapes with \u off, octal truncation and octal end
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(esu_pkg::CH_LOW);
    text_q.push_back(esu_pkg::CH_HIGH);
    queue_text("\\E\\u^?\\777\\1\\n");
    phases++;
    drain();

    // \u on: three-byte UTF-8 with a non-digit inside the escape
    write_utf8_enable(1'b1);
    queue_text("\\u9x999");
    phases++;
    drain();

    for (int p = 0; p < 4; p++) begin
      write_utf8_enable(p[0]);
      while (text_q.size() < PHASE_ITEMS) queue_random_sequence();
      phases++;
      drain();
    end

    if (decoded_q.size() != 0) begin
      note_error($sformatf("%0d decoded bytes never arrived", decoded_q.size()));
    end
    $display("covered %0d input bytes and %0d decoded bytes (%0d multi-byte runs)",
             items_in, bytes_out, multi_runs);
    $display("over %0d phases alternating utf8_enable, %0d mismatches", phases, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
